FILE: src/bwsh_pkg.sv
package bwsh_pkg;

    localparam int POS_FRAC_BITS = 20;
    localparam int ANGLE_ITERS = 18;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_ITERS = (ANGLE_ITERS < ATAN_ENTRIES) ? ANGLE_ITERS : ATAN_ENTRIES;
    localparam int STEP_SHIFT = 28 - POS_FRAC_BITS;
    localparam int CMP_SHIFT_DN = (2 * POS_FRAC_BITS >= 40) ? 2 * POS_FRAC_BITS - 40 : 0;
    localparam int CMP_SHIFT_UP = (2 * POS_FRAC_BITS < 40) ? 40 - 2 * POS_FRAC_BITS : 0;

    localparam logic [39:0] CNT_MAX = 40'hFF_FFFF_FFFF;
    localparam logic signed [18:0] PI_Q16 = 19'sd205887;
    localparam logic signed [18:0] HALF_PI_Q16 = 19'sd102944;

    localparam logic [1:0] REG_CUTOFF = 2'd0;
    localparam logic [1:0] REG_RADIUS = 2'd1;
    localparam logic [1:0] REG_CENTER = 2'd2;
    localparam logic [1:0] REG_SCALE = 2'd3;

    localparam logic KIND_HIT = 1'b0;
    localparam logic KIND_LOST = 1'b1;

    typedef struct packed {
        logic mul_en;
        logic pos_en;
        logic sq_en;
        logic clr;
    } t_lane_ctl;

    typedef struct packed {
        logic [39:0] hit_number;
        logic [39:0] particle_number;
        logic [39:0] step_number;
        logic signed [31:0] out_z;
        logic signed [31:0] out_y;
        logic signed [31:0] out_x;
        logic signed [18:0] azimuth;
        logic [17:0] polar_angle;
    } t_result;

    function automatic logic [39:0] cnt_inc(input logic [39:0] c);
        return (c == CNT_MAX) ? CNT_MAX : c + 40'd1;
    endfunction

    function automatic logic signed [18:0] atan_entry(input logic [4:0] i);
        logic signed [18:0] v;
        case (i)
            5'd0: v = 19'sd51472;
            5'd1: v = 19'sd30386;
            5'd2: v = 19'sd16055;
            5'd3: v = 19'sd8150;
            5'd4: v = 19'sd4091;
            5'd5: v = 19'sd2047;
            5'd6: v = 19'sd1024;
            5'd7: v = 19'sd512;
            5'd8: v = 19'sd256;
            5'd9: v = 19'sd128;
            5'd10: v = 19'sd64;
            5'd11: v = 19'sd32;
            5'd12: v = 19'sd16;
            5'd13: v = 19'sd8;
            5'd14: v = 19'sd4;
            5'd15: v = 19'sd2;
            5'd16: v = 19'sd1;
            default: v = 19'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/brownian_walk_sphere_hit_core.sv
// Brownian walker with sphere-hit and loss detection.
// Input: s_axis carries one item of three Q4.12 noise samples in tdata
// (noise_x in the lowest bits). Output: m_axis carries results; tuser is the
// kind (hit or lost), tlast marks the final result of an input item.
// Configuration: APB registers cutoff_squared, radius_squared,
// sphere_center_x and step_scale at byte addresses 0, 8, 16 and 24.
// Three axis lanes scale the samples, update the position and square it in
// parallel; a merge stage compares the squared distances.
// An item that causes no result passes through the states MUL, POS, SQ and
// CMP before the next item can be accepted; a lost-only item goes on from CMP
// to its output state. A hit runs the bit-serial square root and then the
// polar angle lane (the azimuth lane runs during the square root) before its
// result appears. One item is processed at a time; s_axis_tready is high only
// when the block is idle.
// Reset returns the particle to the origin, clears counters (particle
// number to one) and loads register defaults. When the receiver stalls, the
// result is held until taken and no new item is accepted.
module brownian_walk_sphere_hit_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // noise_x, noise_y, noise_z
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // polar_angle, azimuth, out_x, out_y, out_z, step_number,
    // particle_number, hit_number, zero fill
    output logic [255:0] m_axis_tdata,
    // kind
    output logic         m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL = 4'd1;
    localparam logic [3:0] S_POS = 4'd2;
    localparam logic [3:0] S_SQ = 4'd3;
    localparam logic [3:0] S_CMP = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_ANG = 4'd6;
    localparam logic [3:0] S_OUT_HIT = 4'd7;
    localparam logic [3:0] S_OUT_LOST = 4'd8;

    logic [3:0] r_state;
    logic [49:0] r_cutoff;
    logic [49:0] r_radius;
    logic signed [31:0] r_center;
    logic [15:0] r_scale;
    logic [47:0] r_noise;
    logic [39:0] r_steps;
    logic [39:0] r_particle;
    logic [39:0] r_hits;
    logic r_lost;
    logic r_rel_zero;
    logic signed [32:0] r_relx;
    bwsh_pkg::t_result r_hit_rec;
    bwsh_pkg::t_result r_lost_rec;
    bwsh_pkg::t_result out_rec;
    bwsh_pkg::t_lane_ctl lane_ctl;

    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [32:0] rel_x, rel_y, rel_z;
    logic [63:0] sq_x, sq_y, sq_z, sqr_x, sqr_y, sqr_z;
    logic [63:0] yz2, org2;
    logic [64:0] sph2;
    logic hit, lost;
    logic signed [31:0] relx_sat;
    logic wr_en;
    logic sqrt_done, pol_done, azi_done;
    logic [31:0] rho;
    logic signed [18:0] pol_ang, azi_ang;
    logic accept_in;
    logic out_take;

    assign wr_en = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign accept_in = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_take = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= 50'd439804651110400;
            r_radius <= 50'd1099511627776;
            r_center <= 32'sd5242880;
            r_scale <= 16'd655;
        end else if (wr_en) begin
            unique case (paddr[4:3])
                bwsh_pkg::REG_CUTOFF: r_cutoff <= pwdata[49:0];
                bwsh_pkg::REG_RADIUS: r_radius <= pwdata[49:0];
                bwsh_pkg::REG_CENTER: r_center <= pwdata[31:0];
                bwsh_pkg::REG_SCALE: r_scale <= pwdata[15:0];
                default: r_scale <= r_scale;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            bwsh_pkg::REG_CUTOFF: prdata = 64'(r_cutoff);
            bwsh_pkg::REG_RADIUS: prdata = 64'(r_radius);
            bwsh_pkg::REG_CENTER: prdata = 64'(r_center);
            bwsh_pkg::REG_SCALE: prdata = 64'(r_scale);
            default: prdata = '0;
        endcase
    end

    always_comb begin
        lane_ctl.mul_en = (r_state == S_MUL);
        lane_ctl.pos_en = (r_state == S_POS);
        lane_ctl.sq_en = (r_state == S_SQ);
        lane_ctl.clr = (r_state == S_CMP) && lost;
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_noise <= s_axis_tdata;
        end
    end

    bwsh_axis_lane u_lane_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(lane_ctl),
        .i_noise(r_noise[15:0]), .i_scale(r_scale), .i_offset(r_center),
        .o_pos(pos_x), .o_rel(rel_x), .o_sq_pos(sq_x), .o_sq_rel(sqr_x)
    );

    bwsh_axis_lane u_lane_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(lane_ctl),
        .i_noise(r_noise[31:16]), .i_scale(r_scale), .i_offset(32'sd0),
        .o_pos(pos_y), .o_rel(rel_y), .o_sq_pos(sq_y), .o_sq_rel(sqr_y)
    );

    bwsh_axis_lane u_lane_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(lane_ctl),
        .i_noise(r_noise[47:32]), .i_scale(r_scale), .i_offset(32'sd0),
        .o_pos(pos_z), .o_rel(rel_z), .o_sq_pos(sq_z), .o_sq_rel(sqr_z)
    );

    always_comb begin
        yz2 = sqr_y + sqr_z;
        org2 = yz2 + sq_x;
        sph2 = 65'(yz2) + 65'(sqr_x);
        if (2 * bwsh_pkg::POS_FRAC_BITS >= 40) begin
            hit = (sph2 >> bwsh_pkg::CMP_SHIFT_DN) < 65'(r_radius);
            lost = ((org2 >> bwsh_pkg::CMP_SHIFT_DN) > 64'(r_cutoff))
                || (((org2 >> bwsh_pkg::CMP_SHIFT_DN) == 64'(r_cutoff))
                    && ((org2 & ((64'd1 << bwsh_pkg::CMP_SHIFT_DN) - 64'd1)) != 64'd0));
        end else begin
            hit = sph2 < ((65'(r_radius) + ((65'd1 << bwsh_pkg::CMP_SHIFT_UP) - 65'd1))
                >> bwsh_pkg::CMP_SHIFT_UP);
            lost = org2 > (64'(r_cutoff) >> bwsh_pkg::CMP_SHIFT_UP);
        end
        if (rel_x > 33'sh0_7FFF_FFFF) begin
            relx_sat = 32'sh7FFF_FFFF;
        end else if (rel_x < -33'sh0_8000_0000) begin
            relx_sat = -32'sh8000_0000;
        end else begin
            relx_sat = rel_x[31:0];
        end
    end

    bwsh_isqrt u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start((r_state == S_CMP) && hit), .i_value(yz2),
        .o_done(sqrt_done), .o_root(rho)
    );

    bwsh_cordic u_cordic_azi (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start((r_state == S_CMP) && hit),
        .i_y(34'(pos_y)), .i_x(34'(pos_z)),
        .o_done(azi_done), .o_angle(azi_ang)
    );

    bwsh_cordic u_cordic_pol (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start((r_state == S_SQRT) && sqrt_done),
        .i_y($signed({2'b00, rho})), .i_x(34'(r_relx)),
        .o_done(pol_done), .o_angle(pol_ang)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_steps <= '0;
            r_particle <= 40'd1;
            r_hits <= '0;
            r_lost <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (accept_in) r_state <= S_MUL;
                S_MUL: r_state <= S_POS;
                S_POS: begin
                    r_state <= S_SQ;
                    r_steps <= bwsh_pkg::cnt_inc(r_steps);
                end
                S_SQ: r_state <= S_CMP;
                S_CMP: begin
                    r_lost <= lost;
                    if (hit) begin
                        r_hits <= bwsh_pkg::cnt_inc(r_hits);
                    end
                    if (lost) begin
                        r_steps <= '0;
                        r_particle <= bwsh_pkg::cnt_inc(r_particle);
                    end
                    if (hit) begin
                        r_state <= S_SQRT;
                    end else if (lost) begin
                        r_state <= S_OUT_LOST;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SQRT: if (sqrt_done) r_state <= S_ANG;
                S_ANG: if (azi_done && (pol_done || r_rel_zero)) r_state <= S_OUT_HIT;
                S_OUT_HIT: begin
                    if (out_take) r_state <= r_lost ? S_OUT_LOST : S_IDLE;
                end
                S_OUT_LOST: if (out_take) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP) begin
            r_relx <= rel_x;
            r_rel_zero <= (rel_x == 33'sd0);
            r_hit_rec.polar_angle <= '0;
            r_hit_rec.azimuth <= '0;
            r_hit_rec.out_x <= relx_sat;
            r_hit_rec.out_y <= pos_y;
            r_hit_rec.out_z <= pos_z;
            r_hit_rec.step_number <= r_steps;
            r_hit_rec.particle_number <= r_particle;
            r_hit_rec.hit_number <= hit ? bwsh_pkg::cnt_inc(r_hits) : r_hits;
            r_lost_rec.polar_angle <= '0;
            r_lost_rec.azimuth <= '0;
            r_lost_rec.out_x <= pos_x;
            r_lost_rec.out_y <= pos_y;
            r_lost_rec.out_z <= pos_z;
            r_lost_rec.step_number <= r_steps;
            r_lost_rec.particle_number <= r_particle;
            r_lost_rec.hit_number <= hit ? bwsh_pkg::cnt_inc(r_hits) : r_hits;
        end else if (r_state == S_ANG) begin
            r_hit_rec.azimuth <= azi_ang;
            r_hit_rec.polar_angle <= r_rel_zero ? 18'(bwsh_pkg::HALF_PI_Q16) : 18'(pol_ang);
        end
    end

    always_comb begin
        out_rec = (r_state == S_OUT_LOST) ? r_lost_rec : r_hit_rec;
        m_axis_tvalid = (r_state == S_OUT_HIT) || (r_state == S_OUT_LOST);
        m_axis_tuser = (r_state == S_OUT_LOST) ? bwsh_pkg::KIND_LOST : bwsh_pkg::KIND_HIT;
        m_axis_tlast = (r_state == S_OUT_LOST) || !r_lost;
        m_axis_tdata = {3'b000, out_rec};
    end

endmodule

FILE: src/bwsh_axis_lane.sv
module bwsh_axis_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bwsh_pkg::t_lane_ctl i_ctl,
    input  logic signed [15:0]  i_noise,
    input  logic [15:0]         i_scale,
    input  logic signed [31:0]  i_offset,
    output logic signed [31:0]  o_pos,
    output logic signed [32:0]  o_rel,
    output logic [63:0]         o_sq_pos,
    output logic [63:0]         o_sq_rel
);

    localparam logic signed [33:0] HALF =
        34'((bwsh_pkg::STEP_SHIFT > 0) ? (1 << (bwsh_pkg::STEP_SHIFT - 1)) : 0);

    logic signed [32:0] r_prod;
    logic signed [31:0] r_pos;
    logic signed [31:0] n_pos;
    logic [63:0] r_sq_pos;
    logic [63:0] r_sq_rel;
    logic signed [33:0] rnd;
    logic signed [33:0] sum;
    logic signed [32:0] rel;
    logic [31:0] mag_pos;
    logic [32:0] mag_rel;

    always_comb begin
        rnd = (34'(r_prod) + HALF) >>> bwsh_pkg::STEP_SHIFT;
        sum = 34'(r_pos) + rnd;
        if (sum > 34'sh0_7FFF_FFFF) begin
            n_pos = 32'sh7FFF_FFFF;
        end else if (sum < -34'sh0_8000_0000) begin
            n_pos = -32'sh8000_0000;
        end else begin
            n_pos = sum[31:0];
        end
        rel = 33'(r_pos) - 33'(i_offset);
        mag_pos = r_pos[31] ? 32'(-33'(r_pos)) : 32'(r_pos);
        mag_rel = rel[32] ? 33'(-34'(rel)) : 33'(rel);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= 33'(i_noise) * $signed({1'b0, i_scale});
        end
        if (i_ctl.sq_en) begin
            r_sq_pos <= 64'(mag_pos) * 64'(mag_pos);
            r_sq_rel <= 64'(mag_rel) * 64'(mag_rel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_pos <= '0;
        end else if (i_ctl.pos_en) begin
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;
    assign o_rel = rel;
    assign o_sq_pos = r_sq_pos;
    assign o_sq_rel = r_sq_rel;

endmodule

FILE: src/bwsh_isqrt.sv
module bwsh_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_val;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] rem_sh;
    logic [33:0] trial;

    always_comb begin
        rem_sh = {r_rem[31:0], r_val[63:62]};
        trial = {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_rem <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[61:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem <= rem_sh - trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: src/bwsh_cordic.sv
module bwsh_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [33:0] i_y,
    input  logic signed [33:0] i_x,
    output logic               o_done,
    output logic signed [18:0] o_angle
);

    logic signed [37:0] r_x;
    logic signed [37:0] r_y;
    logic signed [19:0] r_ang;
    logic [4:0] r_i;
    logic r_busy;
    logic r_done;
    logic signed [37:0] dx;
    logic signed [37:0] dy;
    logic signed [19:0] tab;
    logic signed [19:0] ang_clamp;

    always_comb begin
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        tab = 20'(bwsh_pkg::atan_entry(r_i));
        if (r_ang > 20'(bwsh_pkg::PI_Q16)) begin
            ang_clamp = 20'(bwsh_pkg::PI_Q16);
        end else if (r_ang < -20'(bwsh_pkg::PI_Q16)) begin
            ang_clamp = -20'(bwsh_pkg::PI_Q16);
        end else begin
            ang_clamp = r_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_done <= (i_y == 0) || (i_x == 0);
            r_busy <= (i_y != 0) && (i_x != 0);
        end else if (r_busy && r_i == 5'(bwsh_pkg::CORDIC_ITERS - 1)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i <= '0;
            if (i_y == 0) begin
                r_ang <= (i_x < 0) ? 20'(bwsh_pkg::PI_Q16) : 20'sd0;
            end else if (i_x == 0) begin
                r_ang <= (i_y > 0) ? 20'(bwsh_pkg::HALF_PI_Q16) : -20'(bwsh_pkg::HALF_PI_Q16);
            end else if (i_x < 0 && i_y >= 0) begin
                r_x <= 38'(i_y);
                r_y <= -38'(i_x);
                r_ang <= 20'(bwsh_pkg::HALF_PI_Q16);
            end else if (i_x < 0) begin
                r_x <= -38'(i_y);
                r_y <= 38'(i_x);
                r_ang <= -20'(bwsh_pkg::HALF_PI_Q16);
            end else begin
                r_x <= 38'(i_x);
                r_y <= 38'(i_y);
                r_ang <= '0;
            end
        end else if (r_busy) begin
            r_i <= r_i + 5'd1;
            if (r_y >= 0) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_ang <= r_ang + tab;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_ang <= r_ang - tab;
            end
        end
    end

    assign o_done = r_done;
    assign o_angle = ang_clamp[18:0];

endmodule

FILE: src/bwsh_checker.sv
module bwsh_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [255:0] m_axis_tdata,
    input logic         m_axis_tuser,
    input logic         m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input ready while a result is pending");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_polar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[17:0] <= 18'd205887)
        else $error("polar angle out of range");

    a_lost_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[36:0] == 37'd0)
        else $error("lost result malformed");

endmodule

bind brownian_walk_sphere_hit_core bwsh_checker u_bwsh_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);
